// ===== rtl/core/ubd_pkg.sv =====
// Shared types and constants of the baud divisor search block.
package ubd_pkg;

  localparam int unsigned MAX_OVERSAMPLE = 32;
  localparam int unsigned MIN_OVERSAMPLE = 4;
  localparam int unsigned DIVISOR_MAX = 8191;
  localparam int unsigned TOL_DIV = 100;
  localparam int unsigned TOL_MUL = 3;
  localparam logic [31:0] CLK_RESET = 32'd80000000;

  // A rate shifted right by two, times this reciprocal of 25 scaled by 2^30 and then shifted
  // right by 30, is the rate divided by 100 for every 27-bit rate.
  localparam logic [25:0] TOL_RECIP = 26'd42949673;

  localparam int unsigned RATE_W = 27;
  localparam int unsigned RATIO_W = 6;
  localparam int unsigned DIV_W = 13;
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              invalid;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [31:0]        quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [DIV_W-1:0]   divisor;
    logic [31:0]        error;
    logic               within_tol;
    logic               both_edge;
    logic               saturated;
    logic               invalid;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TOL, S_PROD, S_Q0, S_Q0W, S_MUL, S_Q1, S_Q1W, S_Q2, S_Q2W, S_FIN
  } back_state_e;

endpackage

// ===== rtl/core/ubd_front.sv =====
// Front part: accepts request words, flags a zero rate and queues them.
module ubd_front import ubd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [RATE_W-1:0] baud_rate_i,
  output logic              item_valid_o,
  output item_t             item_o,
  input  logic              item_take_i
);

  item_t            slot_q [QDEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full         = (count_q == 2'(QDEPTH));
  assign do_push      = push && !full;
  assign item_valid_o = (count_q != 2'd0);
  assign do_pop       = item_take_i && item_valid_o;
  assign item_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q].rate    <= baud_rate_i;
      slot_q[wr_ptr_q].invalid <= (baud_rate_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/ubd_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module ubd_div import ubd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q;
  logic [32:0] dvs_q;
  logic [33:0] shifted;
  logic        bit_d;

  always_comb begin
    shifted = {rem_q, quo_q[31]};
    bit_d   = (shifted >= {1'b0, dvs_q});
    rem_d   = bit_d ? 33'(shifted - {1'b0, dvs_q}) : shifted[32:0];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], bit_d};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/ubd_back.sv =====
// Back part: runs the ratio search over the shared divider and holds the result word.
module ubd_back import ubd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] clock_hz_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_take_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        res_pop_i
);

  back_state_e        state_q, state_d;
  logic [RATE_W-1:0]  rate_q;
  logic               inv_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [31:0]        tol_q, prod_q, d_q, err_q, best_err_q;
  logic [32:0]        den_q, best_div_q;
  logic [RATIO_W-1:0] best_ratio_q;
  logic               res_valid_q;
  result_t            res_q;
  logic [31:0]        rate32, err_up, cand_err;
  logic [32:0]        cand_div;
  logic               fin_load;
  logic [50:0]        tol_prod;
  logic [20:0]        tol_quo;

  assign rate32 = {{(32-RATE_W){1'b0}}, rate_q};

  assign tol_prod = 51'(rate_q[RATE_W-1:2]) * 51'(TOL_RECIP);
  assign tol_quo  = tol_prod[50:30];

  always_comb begin
    err_up   = rate32 - div_rsp_i.quotient;
    cand_err = (err_q > err_up) ? err_up : err_q;
    cand_div = (err_q > err_up) ? ({1'b0, d_q} + 33'd1) : {1'b0, d_q};
  end

  assign fin_load = (state_q == S_FIN) && (!res_valid_q || res_pop_i);

  always_comb begin
    state_d             = state_q;
    item_take_o         = 1'b0;
    div_req_o.start     = 1'b0;
    div_req_o.dividend  = clock_hz_i;
    div_req_o.divisor   = {1'b0, prod_q};
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          state_d     = item_i.invalid ? S_FIN : S_TOL;
        end
      end
      S_TOL: state_d = S_PROD;
      S_PROD: state_d = S_Q0;
      S_Q0: begin
        div_req_o.start = 1'b1;
        state_d         = S_Q0W;
      end
      S_Q0W: if (div_rsp_i.done) state_d = S_MUL;
      S_MUL: state_d = S_Q1;
      S_Q1: begin
        div_req_o.start   = 1'b1;
        div_req_o.divisor = den_q;
        state_d           = S_Q1W;
      end
      S_Q1W: if (div_rsp_i.done) state_d = S_Q2;
      S_Q2: begin
        div_req_o.start   = 1'b1;
        div_req_o.divisor = den_q + {27'd0, ratio_q};
        state_d           = S_Q2W;
      end
      S_Q2W: begin
        if (div_rsp_i.done) begin
          state_d = (ratio_q == RATIO_W'(MAX_OVERSAMPLE)) ? S_FIN : S_PROD;
        end
      end
      S_FIN: if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_load) res_valid_q <= 1'b1;
      else if (res_pop_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      rate_q       <= item_i.rate;
      inv_q        <= item_i.invalid;
      ratio_q      <= RATIO_W'(MIN_OVERSAMPLE);
      best_err_q   <= {{(32-RATE_W){1'b0}}, item_i.rate};
      best_ratio_q <= '0;
      best_div_q   <= '0;
    end
    if (state_q == S_TOL) tol_q <= {11'd0, tol_quo} * 32'(TOL_MUL);
    if (state_q == S_PROD) prod_q <= 32'(rate_q * ratio_q);
    if (state_q == S_Q0W && div_rsp_i.done) begin
      d_q <= (div_rsp_i.quotient == '0) ? 32'd1 : div_rsp_i.quotient;
    end
    if (state_q == S_MUL) den_q <= 33'(d_q * ratio_q);
    if (state_q == S_Q1W && div_rsp_i.done) err_q <= div_rsp_i.quotient - rate32;
    if (state_q == S_Q2W && div_rsp_i.done) begin
      if (cand_err <= best_err_q) begin
        best_err_q   <= cand_err;
        best_ratio_q <= ratio_q;
        best_div_q   <= cand_div;
      end
      ratio_q <= ratio_q + RATIO_W'(1);
    end
    if (fin_load) begin
      if (inv_q) begin
        res_q.ratio      <= '0;
        res_q.saturated  <= 1'b0;
        res_q.divisor    <= '0;
        res_q.error      <= '0;
        res_q.within_tol <= 1'b0;
        res_q.both_edge  <= 1'b0;
        res_q.invalid    <= 1'b1;
      end else begin
        res_q.ratio      <= best_ratio_q;
        res_q.saturated  <= (best_div_q > 33'(DIVISOR_MAX));
        res_q.divisor    <= (best_div_q > 33'(DIVISOR_MAX)) ? DIV_W'(DIVISOR_MAX)
                                                           : best_div_q[DIV_W-1:0];
        res_q.error      <= best_err_q;
        res_q.within_tol <= (best_err_q < tol_q);
        res_q.both_edge  <= (best_ratio_q >= RATIO_W'(4)) && (best_ratio_q <= RATIO_W'(7));
        res_q.invalid    <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_pop_i |=> res_valid_q && $stable(res_q))
    else $error("result word changed before it was taken");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("divider started while busy");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |-> state_q == S_IDLE)
    else $error("item taken outside idle");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROD) |-> (ratio_q >= RATIO_W'(MIN_OVERSAMPLE))
                         && (ratio_q <= RATIO_W'(MAX_OVERSAMPLE)))
    else $error("ratio out of range");

endmodule

// ===== rtl/core/uart_baud_divisor_search.sv =====
// Top level of the baud divisor search block.
//
// Requests enter through a queue interface: drive baud_rate_i and push while
// full is low. Results leave the same way: while empty is low the oldest word
// is on the result ports, and pop takes it.
// The source clock register is written with cfg_we_i and cfg_wdata_i; reset
// loads 80 MHz. The user must write it only while the block is idle; nothing enforces it.
// A nonzero rate is searched over each of the 29 ratios, with three divisions
// on the one shared radix-2 divider and two set-up states per ratio. The next
// request is taken only once the current result word is loaded. A zero rate
// goes from acceptance straight to S_FIN and then into the result register.
// A two-word queue in front lets requests arrive while a search runs, and a
// result register lets the next search start while a result waits. If the
// receiver stalls, one result is held and the next search stops at its end
// until the first is taken.
// Reset empties both queues and abandons any search in progress.
module uart_baud_divisor_search import ubd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [RATE_W-1:0]  baud_rate_i,
  output logic               empty,
  input  logic               pop,
  output logic [RATIO_W-1:0] oversample_ratio_o,
  output logic [DIV_W-1:0]   baud_divisor_o,
  output logic [31:0]        rate_error_o,
  output logic               within_tolerance_o,
  output logic               both_edge_sampling_o,
  output logic               divisor_saturated_o,
  output logic               invalid_rate_o
);

  logic [31:0] clock_q;
  logic        item_valid, item_take, res_valid;
  item_t       item;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= CLK_RESET;
    end else if (cfg_we_i) begin
      clock_q <= cfg_wdata_i;
    end
  end

  ubd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .baud_rate_i  (baud_rate_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ubd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ubd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clock_hz_i   (clock_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty                = !res_valid;
  assign oversample_ratio_o   = res.ratio;
  assign baud_divisor_o       = res.divisor;
  assign rate_error_o         = res.error;
  assign within_tolerance_o   = res.within_tol;
  assign both_edge_sampling_o = res.both_edge;
  assign divisor_saturated_o  = res.saturated;
  assign invalid_rate_o       = res.invalid;

endmodule

// ===== verif/tb_uart_baud_divisor_search.sv =====
// Self-checking testbench for the baud divisor search block.
`timescale 1ns / 100ps

module tb_uart_baud_divisor_search import ubd_pkg::*; ();

  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned RAND_PER_PHASE = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [RATE_W-1:0]  baud_rate_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [RATIO_W-1:0] oversample_ratio_o;
  logic [DIV_W-1:0]   baud_divisor_o;
  logic [31:0]        rate_error_o;
  logic               within_tolerance_o;
  logic               both_edge_sampling_o;
  logic               divisor_saturated_o;
  logic               invalid_rate_o;

  uart_baud_divisor_search dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .push                (push),
    .full                (full),
    .baud_rate_i         (baud_rate_i),
    .empty               (empty),
    .pop                 (pop),
    .oversample_ratio_o  (oversample_ratio_o),
    .baud_divisor_o      (baud_divisor_o),
    .rate_error_o        (rate_error_o),
    .within_tolerance_o  (within_tolerance_o),
    .both_edge_sampling_o(both_edge_sampling_o),
    .divisor_saturated_o (divisor_saturated_o),
    .invalid_rate_o      (invalid_rate_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [RATE_W-1:0] rate_q[$];
  result_t           search_q[$];
  logic [31:0]       source_clock = CLK_RESET;
  int unsigned       errors = 0;
  int unsigned       words_in = 0;
  int unsigned       words_out = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;
  int unsigned       gap_left = 0;
  int unsigned       stall_left = 0;
  int unsigned       stall_mode = 0;

  function automatic result_t search_best(logic [RATE_W-1:0] rate, logic [31:0] clk_hz);
    result_t     r;
    logic [31:0] rate32;
    logic [31:0] best_err;
    logic [31:0] err;
    logic [31:0] err_up;
    logic [31:0] prod;
    logic [31:0] q0;
    logic [31:0] q1;
    logic [63:0] div;
    logic [63:0] best_div;
    logic [31:0] best_ratio;
    r = '0;
    if (rate == '0) begin
      r.invalid = 1'b1;
      return r;
    end
    rate32 = {{(32-RATE_W){1'b0}}, rate};
    best_err = rate32;
    best_div = '0;
    best_ratio = '0;
    for (int unsigned k = MIN_OVERSAMPLE; k <= MAX_OVERSAMPLE; k++) begin
      prod = rate32 * k;
      div = {32'b0, clk_hz / prod};
      if (div == 0) div = 64'd1;
      q0 = 32'({32'b0, clk_hz} / (64'(k) * div));
      q1 = 32'({32'b0, clk_hz} / (64'(k) * (div + 64'd1)));
      err = q0 - rate32;
      err_up = rate32 - q1;
      if (err > err_up) begin
        err = err_up;
        div = div + 64'd1;
      end
      if (err <= best_err) begin
        best_err = err;
        best_ratio = k;
        best_div = div;
      end
    end
    r.ratio = best_ratio[RATIO_W-1:0];
    r.saturated = best_div > DIVISOR_MAX;
    r.divisor = r.saturated ? DIV_W'(DIVISOR_MAX) : best_div[DIV_W-1:0];
    r.error = best_err;
    r.within_tol = best_err < (rate32 / TOL_DIV) * TOL_MUL;
    r.both_edge = best_ratio >= 4 && best_ratio <= 7;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    logic nxt_push;
    if (push && !full) begin
      search_q.insert(search_q.size(), search_best(baud_rate_i, source_clock));
      void'(rate_q.pop_front());
      words_in++;
    end
    nxt_push = 1'b0;
    if (gap_left > 0) begin
      gap_left--;
    end else if (rate_q.size() > 0 && rst_ni) begin
      nxt_push = 1'b1;
      baud_rate_i <= rate_q[0];
      if (burst_left == 0) burst_left = $urandom_range(1, 12);
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
    push <= nxt_push;
  end

  // Receiver: compares each popped word with the oldest prediction.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (pop && !empty) begin
      words_out++;
      if (search_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, ratio %0d divisor %0d", $time,
                 oversample_ratio_o, baud_divisor_o);
      end else begin
        exp_r = search_q.pop_front();
        if (oversample_ratio_o !== exp_r.ratio) begin
          errors++;
          $display("%0t: ratio expected %0d actual %0d", $time, exp_r.ratio,
                   oversample_ratio_o);
        end
        if (baud_divisor_o !== exp_r.divisor) begin
          errors++;
          $display("%0t: divisor expected %0d actual %0d", $time, exp_r.divisor,
                   baud_divisor_o);
        end
        if (rate_error_o !== exp_r.error) begin
          errors++;
          $display("%0t: error expected %0d actual %0d", $time, exp_r.error, rate_error_o);
        end
        if (within_tolerance_o !== exp_r.within_tol) begin
          errors++;
          $display("%0t: tolerance expected %0b actual %0b", $time, exp_r.within_tol,
                   within_tolerance_o);
        end
        if (both_edge_sampling_o !== exp_r.both_edge) begin
          errors++;
          $display("%0t: both edge expected %0b actual %0b", $time, exp_r.both_edge,
                   both_edge_sampling_o);
        end
        if (divisor_saturated_o !== exp_r.saturated) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.saturated,
                   divisor_saturated_o);
        end
        if (invalid_rate_o !== exp_r.invalid) begin
          errors++;
          $display("%0t: invalid expected %0b actual %0b", $time, exp_r.invalid,
                   invalid_rate_o);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      stall_mode = (stall_mode + 1) % 64;
      if (stall_mode < 20) stall_left = 0;
      else if (stall_mode < 40) stall_left = $urandom_range(0, 3);
      else stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : 0;
      pop <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i); while (rate_q.size() != 0 || search_q.size() != 0 || push);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_clock(logic [31:0] hz);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hz;
    source_clock = hz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [RATE_W-1:0] random_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return RATE_W'($urandom_range(1, 1000));
      3, 4, 5: return RATE_W'($urandom_range(300, 4000000));
      6:       return RATE_W'($urandom_range(4000000, 134217727));
      default: return RATE_W'($urandom);
    endcase
  endfunction

  logic [31:0] clock_plan[6];

  initial begin
    clock_plan = '{32'd1, 32'hFFFFFFFF, 32'd80000000, 32'd1843200, 32'd0, 32'd48000000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (clock_plan[p]) begin
      logic [31:0] hz;
      if (p == 0) begin
        rate_q = '{27'd0, 27'd1, 27'd2, 27'd3, 27'd9600, 27'd115200, 27'd2500000,
                   27'd20000000, 27'd134217727, 27'h5555555, 27'h2AAAAAA, 27'd100,
                   27'd99, 27'd921600};
        wait_drained();
        write_clock(32'd1);
        rate_q = '{27'd0, 27'd1, 27'd134217727};
        wait_drained();
        write_clock(32'hFFFFFFFF);
        rate_q = '{27'd1, 27'd2, 27'd300, 27'd115200, 27'd134217727};
        wait_drained();
      end
      hz = clock_plan[p];
      if (hz == 0) hz = $urandom_range(1, 32'hFFFFFFFE);
      write_clock(hz);
      @(negedge clk_i);
      repeat (RAND_PER_PHASE) rate_q.insert(rate_q.size(), random_rate());
      wait_drained();
    end
    $display("Ran %0d requests, %0d results checked, across %0d source clock settings",
             words_in, words_out, $size(clock_plan) + 2);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
